// ----- design/cvsa_pkg.sv -----
package cvsa_pkg;

    localparam int UV_W       = 23;
    localparam int RAW_W      = 16;
    localparam int GI_W       = 4;
    localparam int CNT_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_LANES  = 4;

    localparam int DEF_NUM_CELLS       = 36;
    localparam int DEF_CELLS_PER_GROUP = 4;

    localparam logic [UV_W-1:0] UV_PER_UNIT    = 23'd100;
    localparam logic [UV_W-1:0] VALID_FLOOR_UV = 23'd1000;
    localparam logic [UV_W-1:0] WARN_HIGH_RST  = 23'd4200000;
    localparam logic [UV_W-1:0] WARN_LOW_RST   = 23'd2500000;

    localparam logic [CFG_IDX_W-1:0] REG_WARN_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_LOW  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic write;
        logic scan_start;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic wr_last;
        logic scan_done;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ----- design/cvsa_div.sv -----
module cvsa_div #(
    parameter int DW = 26,
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int KW = $clog2(DW + 1);

    logic [KW-1:0] iter_reg, iter_next;
    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        iter_next = iter_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            iter_next = KW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (iter_reg != '0)
        begin
            iter_next = iter_reg - 1'b1;
            quo_next  = {quo_reg[DW-2:0], ge};
            rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
            done_next = (iter_reg == KW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/cvsa_datapath.sv -----
module cvsa_datapath #(
    parameter int NUM_CELLS       = cvsa_pkg::DEF_NUM_CELLS,
    parameter int CELLS_PER_GROUP = cvsa_pkg::DEF_CELLS_PER_GROUP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cvsa_pkg::cmd_t                      cmd,
    output cvsa_pkg::stat_t                     stat,
    input  logic                                cfg_we,
    input  logic [cvsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cvsa_pkg::UV_W-1:0]           cfg_wdata,
    input  logic [cvsa_pkg::GI_W-1:0]           group_index,
    input  logic [cvsa_pkg::RAW_W-1:0]          cell_a,
    input  logic [cvsa_pkg::RAW_W-1:0]          cell_b,
    input  logic [cvsa_pkg::RAW_W-1:0]          cell_c,
    input  logic [cvsa_pkg::RAW_W-1:0]          cell_d,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [cvsa_pkg::UV_W-1:0]           min_uv,
    output logic [cvsa_pkg::UV_W-1:0]           mean_uv,
    output logic [cvsa_pkg::UV_W-1:0]           max_uv,
    output logic [cvsa_pkg::CNT_OUT_W-1:0]      valid_count,
    output logic                                alarm_active,
    output logic                                alarm_over,
    output logic [cvsa_pkg::UV_W-1:0]           alarm_value_uv
);
    import cvsa_pkg::*;

    localparam int LANES = (CELLS_PER_GROUP < MAX_LANES) ? CELLS_PER_GROUP : MAX_LANES;
    localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int AW    = $clog2(NUM_CELLS);
    localparam int CW    = $clog2(NUM_CELLS + 1);
    localparam int SW    = UV_W + CW;
    localparam int POS_W = GI_W + $clog2(CELLS_PER_GROUP) + 1;
    localparam int CXW   = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    // thresholds
    logic [UV_W-1:0] warn_high_reg, warn_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_high_reg <= WARN_HIGH_RST;
            warn_low_reg  <= WARN_LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WARN_HIGH: warn_high_reg <= cfg_wdata;
                REG_WARN_LOW:  warn_low_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // captured word
    logic [RAW_W-1:0] in_cells [MAX_LANES];
    logic [RAW_W-1:0] cap_reg [LANES];
    logic [GI_W-1:0]  gi_reg;

    assign in_cells[0] = cell_a;
    assign in_cells[1] = cell_b;
    assign in_cells[2] = cell_c;
    assign in_cells[3] = cell_d;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gi_reg <= group_index;
            for (int l = 0; l < LANES; l++)
            begin
                cap_reg[l] <= in_cells[l];
            end
        end
    end

    // write pass, one lane a cycle
    logic [LW-1:0]    lane_reg;
    logic [POS_W-1:0] pos;
    logic             pos_ok;

    assign pos    = POS_W'(gi_reg) * POS_W'(CELLS_PER_GROUP) + POS_W'(lane_reg);
    assign pos_ok = 32'(pos) < NUM_CELLS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (cmd.capture)
        begin
            lane_reg <= '0;
        end
        else if (cmd.write)
        begin
            lane_reg <= lane_reg + 1'b1;
        end
    end

    assign stat.wr_last = (lane_reg == LW'(LANES - 1));

    // cell store with per-entry valid bits
    logic [RAW_W-1:0]     mem [NUM_CELLS];
    logic [NUM_CELLS-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write && pos_ok)
        begin
            mem[pos[AW-1:0]] <= cap_reg[lane_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.write && pos_ok)
        begin
            vld_reg[pos[AW-1:0]] <= 1'b1;
        end
    end

    // scan pipeline: read, scale, accumulate
    logic             scan_busy_reg;
    logic [AW-1:0]    addr_reg;
    logic             s1_vld_reg, s1_last_reg, s1_ok_reg;
    logic [RAW_W-1:0] s1_data_reg;
    logic             s2_vld_reg, s2_last_reg;
    logic [UV_W-1:0]  s2_uv_reg;
    logic             scan_done_reg;
    logic             addr_last;
    logic [UV_W-1:0]  scaled;

    assign addr_last = (addr_reg == AW'(NUM_CELLS - 1));
    assign scaled    = (s1_ok_reg ? {7'd0, s1_data_reg} : '0) * UV_PER_UNIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg <= 1'b0;
            addr_reg      <= '0;
            s1_vld_reg    <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_last_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                addr_reg      <= '0;
            end
            else if (scan_busy_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_last)
                begin
                    scan_busy_reg <= 1'b0;
                end
            end
            s1_vld_reg    <= scan_busy_reg;
            s1_last_reg   <= scan_busy_reg && addr_last;
            s2_vld_reg    <= s1_vld_reg;
            s2_last_reg   <= s1_vld_reg && s1_last_reg;
            scan_done_reg <= s2_vld_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= mem[addr_reg];
        s1_ok_reg   <= vld_reg[addr_reg];
        s2_uv_reg   <= scaled;
    end

    assign stat.scan_done = scan_done_reg;

    logic [UV_W-1:0] lo_reg, hi_reg;
    logic [SW-1:0]   sum_reg;
    logic [CW-1:0]   count_reg;
    logic            alarm_on_reg, alarm_high_reg;
    logic [UV_W-1:0] alarm_uv_reg;
    logic            cell_valid;

    assign cell_valid = s2_vld_reg && (s2_uv_reg > VALID_FLOOR_UV);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cell_valid)
        begin
            if (count_reg == '0 || s2_uv_reg < lo_reg)
            begin
                lo_reg <= s2_uv_reg;
            end
            if (s2_uv_reg > hi_reg)
            begin
                hi_reg <= s2_uv_reg;
            end
            sum_reg   <= sum_reg + SW'(s2_uv_reg);
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_on_reg   <= 1'b0;
            alarm_high_reg <= 1'b0;
            alarm_uv_reg   <= '0;
        end
        else if (cell_valid)
        begin
            if (s2_uv_reg > warn_high_reg)
            begin
                alarm_on_reg   <= 1'b1;
                alarm_high_reg <= 1'b1;
                alarm_uv_reg   <= s2_uv_reg;
            end
            else if (s2_uv_reg < warn_low_reg)
            begin
                alarm_on_reg   <= 1'b1;
                alarm_high_reg <= 1'b0;
                alarm_uv_reg   <= s2_uv_reg;
            end
            else
            begin
                alarm_on_reg   <= 1'b0;
                alarm_high_reg <= 1'b0;
            end
        end
    end

    // mean
    logic [SW-1:0] quotient;

    cvsa_div #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (stat.div_done),
        .quotient (quotient)
    );

    // output register
    logic                 out_valid_reg;
    logic [UV_W-1:0]      min_out_reg, mean_out_reg, max_out_reg, alarm_val_out_reg;
    logic [CNT_OUT_W-1:0] count_out_reg;
    logic                 active_out_reg, over_out_reg;
    logic [CXW-1:0]       count_ext;

    assign count_ext = CXW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            min_out_reg       <= lo_reg;
            max_out_reg       <= hi_reg;
            mean_out_reg      <= (count_reg == '0) ? '0 : quotient[UV_W-1:0];
            count_out_reg     <= count_ext[CNT_OUT_W-1:0];
            active_out_reg    <= alarm_on_reg;
            over_out_reg      <= alarm_high_reg;
            alarm_val_out_reg <= alarm_uv_reg;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign min_uv         = min_out_reg;
    assign mean_uv        = mean_out_reg;
    assign max_uv         = max_out_reg;
    assign valid_count    = count_out_reg;
    assign alarm_active   = active_out_reg;
    assign alarm_over     = over_out_reg;
    assign alarm_value_uv = alarm_val_out_reg;

endmodule

// ----- design/cvsa_ctrl.sv -----
module cvsa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cvsa_pkg::stat_t stat,
    output cvsa_pkg::cmd_t  cmd
);
    import cvsa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.wr_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cell_voltage_stats_alarm_top.sv -----
// channel   signals                                   dir   moves
// in        in_valid/in_ready, group_index, cell_a-d  in    one group of raw readings
// out       out_valid/out_ready, min/mean/max, alarm  out   statistics and alarm word
// cfg       cfg_we, cfg_index, cfg_wdata              in    threshold register write
//
// one word takes a capture, a write for each of min(CELLS_PER_GROUP,4) lanes, a scan of
// all NUM_CELLS entries through the cell store, a divide of 23 + clog2(NUM_CELLS+1)
// quotient bits, a state to see the divider finish and one output load
// reset clears the store valid bits and the alarm and loads the default thresholds at once
// the next word is taken while a result waits; a stalled result holds the
// controller before the output load
module cell_voltage_stats_alarm_top #(
    parameter int NUM_CELLS       = cvsa_pkg::DEF_NUM_CELLS,
    parameter int CELLS_PER_GROUP = cvsa_pkg::DEF_CELLS_PER_GROUP
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cvsa_pkg::GI_W-1:0]      group_index,
    input  logic [cvsa_pkg::RAW_W-1:0]     cell_a,
    input  logic [cvsa_pkg::RAW_W-1:0]     cell_b,
    input  logic [cvsa_pkg::RAW_W-1:0]     cell_c,
    input  logic [cvsa_pkg::RAW_W-1:0]     cell_d,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cvsa_pkg::UV_W-1:0]      min_uv,
    output logic [cvsa_pkg::UV_W-1:0]      mean_uv,
    output logic [cvsa_pkg::UV_W-1:0]      max_uv,
    output logic [cvsa_pkg::CNT_OUT_W-1:0] valid_count,
    output logic                           alarm_active,
    output logic                           alarm_over,
    output logic [cvsa_pkg::UV_W-1:0]      alarm_value_uv,
    input  logic                           cfg_we,
    input  logic [cvsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cvsa_pkg::UV_W-1:0]      cfg_wdata
);
    import cvsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cvsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cvsa_datapath #(
        .NUM_CELLS       (NUM_CELLS),
        .CELLS_PER_GROUP (CELLS_PER_GROUP)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .group_index    (group_index),
        .cell_a         (cell_a),
        .cell_b         (cell_b),
        .cell_c         (cell_c),
        .cell_d         (cell_d),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .min_uv         (min_uv),
        .mean_uv        (mean_uv),
        .max_uv         (max_uv),
        .valid_count    (valid_count),
        .alarm_active   (alarm_active),
        .alarm_over     (alarm_over),
        .alarm_value_uv (alarm_value_uv)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while a scan is running");

    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_count == '0 && NUM_CELLS < 64)
        |-> (min_uv == '0 && max_uv == '0 && mean_uv == '0))
        else $error("statistics nonzero with no valid cell");

    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_count != '0) |-> (min_uv <= mean_uv && mean_uv <= max_uv))
        else $error("mean outside min and max");

    a_over_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm_over) |-> alarm_active)
        else $error("over flag without standing alarm");

endmodule
